>>> src/irpd_pkg.sv
// Shared types and constants for the IR RGB pulse-distance encoder.
// Used by irpd_front, irpd_back and the top level.
package irpd_pkg;

    localparam int COLOUR_W   = 8;
    localparam int DURATION_W = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_MARK        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_SPACE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_SPACE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRAILER     = 3'd3;

    localparam logic [DURATION_W-1:0] MARK_RESET       = 16'd500;
    localparam logic [DURATION_W-1:0] ONE_SPACE_RESET  = 16'd2500;
    localparam logic [DURATION_W-1:0] ZERO_SPACE_RESET = 16'd1950;
    localparam logic [DURATION_W-1:0] TRAILER_RESET    = 16'd450;

    typedef struct packed {
        logic [DURATION_W-1:0] mark_us;
        logic [DURATION_W-1:0] one_space_us;
        logic [DURATION_W-1:0] zero_space_us;
        logic [DURATION_W-1:0] trailer_mark_us;
    } timing_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MARK  = 4'b0010,
        ST_SPACE = 4'b0100,
        ST_TRAIL = 4'b1000
    } back_state_t;

endpackage

>>> src/irpd_front.sv
// Front end: accepts a colour request, keeps the top bits of each channel
// and builds the frame bit pattern. Depends on irpd_pkg.
module irpd_front #(
    parameter int BITS = 5,
    parameter int PAT_W = 6 * BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [irpd_pkg::COLOUR_W-1:0]  red,
    input  logic [irpd_pkg::COLOUR_W-1:0]  green,
    input  logic [irpd_pkg::COLOUR_W-1:0]  blue,
    output logic                           pat_valid,
    input  logic                           pat_ready,
    output logic [PAT_W-1:0]               pat
);

    logic             valid_reg;
    logic             valid_next;
    logic [PAT_W-1:0] pat_reg;
    logic [BITS-1:0]  r_bits;
    logic [BITS-1:0]  g_bits;
    logic [BITS-1:0]  b_bits;

    assign r_bits = red[irpd_pkg::COLOUR_W-1 -: BITS];
    assign g_bits = green[irpd_pkg::COLOUR_W-1 -: BITS];
    assign b_bits = blue[irpd_pkg::COLOUR_W-1 -: BITS];

    assign in_ready  = !valid_reg || pat_ready;
    assign pat_valid = valid_reg;
    assign pat       = pat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pat_reg <= {r_bits, g_bits, b_bits, ~r_bits, ~g_bits, ~b_bits};
        end
    end

endmodule

>>> src/irpd_queue.sv
// Two-entry queue between front and back ends.
// No package dependency.
module irpd_queue #(
    parameter int WIDTH = 30
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/irpd_back.sv
// Back end: serializes one frame pattern into mark/space durations through
// an output register. Depends on irpd_pkg.
module irpd_back #(
    parameter int PAT_W = 30
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  irpd_pkg::timing_t                timing,
    input  logic                             pat_valid,
    output logic                             pat_ready,
    input  logic [PAT_W-1:0]                 pat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [irpd_pkg::DURATION_W-1:0]  duration_us,
    output logic                             is_mark,
    output logic                             last
);

    localparam int CNT_W = $clog2(PAT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAT_W - 1);

    irpd_pkg::back_state_t            state_reg, state_next;
    logic [PAT_W-1:0]                 shift_reg, shift_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             out_valid_reg, out_valid_next;
    logic [irpd_pkg::DURATION_W-1:0]  dur_reg, dur_next;
    logic                             mark_reg, mark_next;
    logic                             last_reg, last_next;
    logic                             advance;

    assign advance     = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign duration_us = dur_reg;
    assign is_mark     = mark_reg;
    assign last        = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        dur_next       = dur_reg;
        mark_next      = mark_reg;
        last_next      = last_reg;
        pat_ready      = 1'b0;
        if (advance)
        begin
            out_valid_next = 1'b0;
            unique case (state_reg)
                irpd_pkg::ST_IDLE:
                begin
                    if (pat_valid)
                    begin
                        pat_ready      = 1'b1;
                        shift_next     = pat;
                        cnt_next       = '0;
                        out_valid_next = 1'b1;
                        dur_next       = timing.mark_us;
                        mark_next      = 1'b1;
                        last_next      = 1'b0;
                        state_next     = irpd_pkg::ST_SPACE;
                    end
                end
                irpd_pkg::ST_MARK:
                begin
                    out_valid_next = 1'b1;
                    dur_next       = timing.mark_us;
                    mark_next      = 1'b1;
                    last_next      = 1'b0;
                    state_next     = irpd_pkg::ST_SPACE;
                end
                irpd_pkg::ST_SPACE:
                begin
                    out_valid_next = 1'b1;
                    dur_next       = shift_reg[PAT_W-1] ? timing.one_space_us
                                                        : timing.zero_space_us;
                    mark_next      = 1'b0;
                    last_next      = 1'b0;
                    shift_next     = {shift_reg[PAT_W-2:0], 1'b0};
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_next = irpd_pkg::ST_TRAIL;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CNT_W'(1);
                        state_next = irpd_pkg::ST_MARK;
                    end
                end
                irpd_pkg::ST_TRAIL:
                begin
                    out_valid_next = 1'b1;
                    dur_next       = timing.trailer_mark_us;
                    mark_next      = 1'b1;
                    last_next      = 1'b1;
                    // chain straight into the next frame
                    if (pat_valid)
                    begin
                        pat_ready  = 1'b1;
                        shift_next = pat;
                        cnt_next   = '0;
                        state_next = irpd_pkg::ST_MARK;
                    end
                    else
                    begin
                        state_next = irpd_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = irpd_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= irpd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        cnt_reg   <= cnt_next;
        dur_reg   <= dur_next;
        mark_reg  <= mark_next;
        last_reg  <= last_next;
    end

endmodule

>>> src/ir_rgb_pulse_distance_encoder.sv
// Top level of the IR RGB pulse-distance encoder: timing registers,
// front end, queue and back end. Depends on irpd_pkg, irpd_front,
// irpd_queue and irpd_back.
//
// Channel  Direction  Handshake             Payload
// in       input      in_valid/in_ready     red, green, blue (8b each)
// out      output     out_valid/out_ready   duration_us (16b), is_mark, last
// cfg      input      cfg_valid/cfg_ready   cfg_index (3b), cfg_data (16b)
//
// One frame is 12*BITS_PER_COLOUR+1 results, one per cycle from the output
// register while out_ready is high. Frames run back to back; the front end
// and a two-entry queue take the next colours meanwhile. An output stall
// holds the serializer; once the queue and front register fill, in_ready
// drops.
// Reset restores the timing registers to their defaults; cfg_ready is high.
module ir_rgb_pulse_distance_encoder #(
    parameter int BITS_PER_COLOUR = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [irpd_pkg::COLOUR_W-1:0]       red,
    input  logic [irpd_pkg::COLOUR_W-1:0]       green,
    input  logic [irpd_pkg::COLOUR_W-1:0]       blue,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [irpd_pkg::DURATION_W-1:0]     duration_us,
    output logic                                is_mark,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [irpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [irpd_pkg::DURATION_W-1:0]     cfg_data
);

    localparam int PAT_W = 6 * BITS_PER_COLOUR;

    irpd_pkg::timing_t timing_reg, timing_next;
    logic              f_valid;
    logic              f_ready;
    logic [PAT_W-1:0]  f_pat;
    logic              q_valid;
    logic              q_ready;
    logic [PAT_W-1:0]  q_pat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        timing_next = timing_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                irpd_pkg::REG_MARK:       timing_next.mark_us         = cfg_data;
                irpd_pkg::REG_ONE_SPACE:  timing_next.one_space_us    = cfg_data;
                irpd_pkg::REG_ZERO_SPACE: timing_next.zero_space_us   = cfg_data;
                irpd_pkg::REG_TRAILER:    timing_next.trailer_mark_us = cfg_data;
                default:                  timing_next = timing_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.mark_us         <= irpd_pkg::MARK_RESET;
            timing_reg.one_space_us    <= irpd_pkg::ONE_SPACE_RESET;
            timing_reg.zero_space_us   <= irpd_pkg::ZERO_SPACE_RESET;
            timing_reg.trailer_mark_us <= irpd_pkg::TRAILER_RESET;
        end
        else
        begin
            timing_reg <= timing_next;
        end
    end

    irpd_front #(
        .BITS  (BITS_PER_COLOUR),
        .PAT_W (PAT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .pat_valid (f_valid),
        .pat_ready (f_ready),
        .pat       (f_pat)
    );

    irpd_queue #(
        .WIDTH (PAT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_pat),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_pat)
    );

    irpd_back #(
        .PAT_W (PAT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .timing      (timing_reg),
        .pat_valid   (q_valid),
        .pat_ready   (q_ready),
        .pat         (q_pat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .duration_us (duration_us),
        .is_mark     (is_mark),
        .last        (last)
    );

endmodule

>>> dv/testbench.sv
// Testbench for ir_rgb_pulse_distance_encoder: random and directed colours,
// timing register writes between phases, and a frame predictor checked per pulse.
// Depends on irpd_pkg and the RTL of the encoder only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BPC        = 5;
    localparam int STALL_CYC  = 400;
    localparam int WDOG_LIMIT = 4000;
    localparam int TAIL_CYC   = 20;
    localparam int CW         = irpd_pkg::COLOUR_W;
    localparam int DW         = irpd_pkg::DURATION_W;
    localparam int IW         = irpd_pkg::CFG_INDEX_W;

    typedef struct packed {
        logic [CW-1:0] r;
        logic [CW-1:0] g;
        logic [CW-1:0] b;
    } colour_t;

    typedef struct packed {
        logic [DW-1:0] dur;
        logic          mark;
        logic          fin;
    } pulse_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [CW-1:0] red = '0;
    logic [CW-1:0] green = '0;
    logic [CW-1:0] blue = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [DW-1:0] duration_us;
    logic          is_mark;
    logic          last;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [IW-1:0] cfg_index = '0;
    logic [DW-1:0] cfg_data = '0;

    colour_t           colour_q[$];
    pulse_t            pulse_q[$];
    irpd_pkg::timing_t timing_mirror;
    logic              in_taken = 1'b0;
    bit                idle_en = 1'b1;
    bit                hold_req = 1'b0;
    bit                hold_taken = 1'b0;
    int                hold_left = 0;
    int                mismatches = 0;
    int                quiet_cycles = 0;

    ir_rgb_pulse_distance_encoder #(.BITS_PER_COLOUR(BPC)) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .duration_us (duration_us),
        .is_mark     (is_mark),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic void expand_frame(colour_t c);
        logic [BPC-1:0] words[6];
        pulse_t         p;
        words[0] = c.r[CW-1 -: BPC];
        words[1] = c.g[CW-1 -: BPC];
        words[2] = c.b[CW-1 -: BPC];
        words[3] = ~words[0];
        words[4] = ~words[1];
        words[5] = ~words[2];
        for (int w = 0; w < 6; w++)
        begin
            for (int i = BPC - 1; i >= 0; i--)
            begin
                p = '{dur: timing_mirror.mark_us, mark: 1'b1, fin: 1'b0};
                pulse_q.push_back(p);
                p.dur  = words[w][i] ? timing_mirror.one_space_us : timing_mirror.zero_space_us;
                p.mark = 1'b0;
                pulse_q.push_back(p);
            end
        end
        p = '{dur: timing_mirror.trailer_mark_us, mark: 1'b1, fin: 1'b1};
        pulse_q.push_back(p);
    endfunction

    function automatic void check_field(string fld, logic [DW-1:0] exp_v,
                                        logic [DW-1:0] act_v);
        if (act_v !== exp_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, fld, exp_v, act_v);
        end
    endfunction

    // request tracking, prediction, checking and watchdog
    always @(posedge clk)
    begin
        pulse_t  exp_p;
        colour_t c_in;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    irpd_pkg::REG_MARK:       timing_mirror.mark_us = cfg_data;
                    irpd_pkg::REG_ONE_SPACE:  timing_mirror.one_space_us = cfg_data;
                    irpd_pkg::REG_ZERO_SPACE: timing_mirror.zero_space_us = cfg_data;
                    irpd_pkg::REG_TRAILER:    timing_mirror.trailer_mark_us = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                c_in.r = red;
                c_in.g = green;
                c_in.b = blue;
                expand_frame(c_in);
            end
            if (out_valid && out_ready)
            begin
                if (pulse_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected pulse: expected none, %s %0d mark %0b last %0b",
                             $time, "actual dur", duration_us, is_mark, last);
                end
                else
                begin
                    exp_p = pulse_q.pop_front();
                    check_field("duration_us", exp_p.dur, duration_us);
                    check_field("is_mark", DW'(exp_p.mark), DW'(is_mark));
                    check_field("last", DW'(exp_p.fin), DW'(last));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= WDOG_LIMIT)
            begin
                $display("%0t: timeout, %0d pulses outstanding", $time, pulse_q.size());
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // colour request driver
    always @(negedge clk)
    begin
        colour_t c;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (colour_q.size() != 0 && !(idle_en && $urandom_range(99) < 30))
            begin
                c = colour_q.pop_front();
                in_valid <= 1'b1;
                red      <= c.r;
                green    <= c.g;
                blue     <= c.b;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // pulse receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= STALL_CYC;
            out_ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !idle_en || ($urandom_range(99) >= 30);
    end

    task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_timing(input logic [DW-1:0] m, input logic [DW-1:0] one,
                                input logic [DW-1:0] zero, input logic [DW-1:0] tr);
        write_reg(irpd_pkg::REG_MARK, m);
        write_reg(irpd_pkg::REG_ONE_SPACE, one);
        write_reg(irpd_pkg::REG_ZERO_SPACE, zero);
        write_reg(irpd_pkg::REG_TRAILER, tr);
    endtask

    task automatic send(input logic [CW-1:0] r, input logic [CW-1:0] g,
                        input logic [CW-1:0] b);
        colour_t c;
        c.r = r;
        c.g = g;
        c.b = b;
        colour_q.push_back(c);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send(CW'($urandom_range(255)), CW'($urandom_range(255)), CW'($urandom_range(255)));
    endtask

    // sampled at the rising edge, where the driver and the queues are stable
    task automatic settle();
        @(posedge clk);
        while (colour_q.size() != 0 || in_valid || pulse_q.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        timing_mirror = '{mark_us: irpd_pkg::MARK_RESET,
                          one_space_us: irpd_pkg::ONE_SPACE_RESET,
                          zero_space_us: irpd_pkg::ZERO_SPACE_RESET,
                          trailer_mark_us: irpd_pkg::TRAILER_RESET};
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset timings: extremes, masked low bits, single bits
        send(8'h00, 8'h00, 8'h00);
        send(8'hFF, 8'hFF, 8'hFF);
        send(8'hF8, 8'hF8, 8'hF8);
        send(8'h07, 8'h07, 8'h07);
        send(8'hAA, 8'h55, 8'hAA);
        send(8'h55, 8'hAA, 8'h55);
        send(8'hFF, 8'h00, 8'h00);
        send(8'h00, 8'hFF, 8'h00);
        send(8'h00, 8'h00, 8'hFF);
        send(8'h80, 8'h40, 8'h20);
        send(8'h10, 8'h08, 8'h80);
        send(8'h84, 8'h42, 8'h21);
        settle();

        // zero-length timings, ignored out-of-range index, long receiver stall
        write_timing(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        write_reg(IW'(int'(irpd_pkg::REG_TRAILER) + 1 +
                      $urandom_range((1 << IW) - 2 - int'(irpd_pkg::REG_TRAILER))),
                  DW'($urandom_range(16'hFFFF)));
        @(posedge clk);
        hold_req = 1'b1;
        send(8'hFF, 8'h00, 8'hFF);
        send_random(40);
        settle();

        // all-ones timings, no idling on either side
        write_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_en = 1'b0;
        send(8'h00, 8'hFF, 8'h00);
        send_random(40);
        settle();

        idle_en = 1'b1;
        write_timing(DW'($urandom_range(16'hFFFF)), DW'($urandom_range(16'hFFFF)),
                     DW'($urandom_range(16'hFFFF)), DW'($urandom_range(16'hFFFF)));
        for (int i = int'(irpd_pkg::REG_TRAILER) + 1; i < (1 << IW); i++)
            write_reg(IW'(i), DW'($urandom_range(16'hFFFF)));
        send_random(50);
        settle();

        write_timing(16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF);
        send_random(50);
        settle();

        write_timing(DW'($urandom_range(16'hFFFF)), DW'($urandom_range(16'hFFFF)),
                     DW'($urandom_range(16'hFFFF)), DW'($urandom_range(16'hFFFF)));
        send_random(74);
        settle();

        repeat (TAIL_CYC) @(negedge clk);
        if (mismatches == 0 && pulse_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
